@@ src/tsc_pkg.sv @@
// shared types and codes for the trade side classifier
package tsc_pkg;

  // register file geometry
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_QUOTE_AGE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRICE_TOLERANCE = 1'd1;

  // item kinds
  typedef enum logic {
    KIND_QUOTE = 1'b0,
    KIND_TRADE = 1'b1
  } kind_t;

  // classified side
  typedef enum logic [1:0] {
    SIDE_UNKNOWN = 2'd0,
    SIDE_BUY     = 2'd1,
    SIDE_SELL    = 2'd2
  } side_t;

  // classification method
  typedef enum logic [1:0] {
    METHOD_UNKNOWN = 2'd0,
    METHOD_QUOTE   = 2'd1,
    METHOD_TICK    = 2'd2
  } method_t;

  // input word
  typedef struct packed {
    kind_t              kind;
    logic [39:0]        time_seconds;
    logic signed [31:0] trade_price;
    logic signed [31:0] trade_size;
    logic               trade_finite;
    logic signed [31:0] quote_bid;
    logic signed [31:0] quote_ask;
  } in_word_t;

  // result word
  typedef struct packed {
    side_t              side;
    method_t            method;
    logic [39:0]        out_time;
    logic signed [31:0] out_price;
    logic signed [31:0] out_size;
  } out_word_t;

  // configuration register contents
  typedef struct packed {
    logic [31:0] max_quote_age;
    logic [30:0] price_tolerance;
  } cfg_t;

endpackage

@@ src/tsc_cfg_regs.sv @@
// configuration registers of the trade side classifier
module tsc_cfg_regs
  import tsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // register writes, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MAX_QUOTE_AGE: begin
          cfg_r.max_quote_age <= cfg_wdata;
        end
        CFG_IDX_PRICE_TOLERANCE: begin
          cfg_r.price_tolerance <= cfg_wdata[30:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/tsc_classify.sv @@
// quote test and tick rule with the held quote and last trade state
module tsc_classify
  import tsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_word_t  item,
  input  logic      commit,
  output out_word_t res
);

  logic signed [31:0] held_bid_r,  held_bid_nxt;
  logic signed [31:0] held_ask_r,  held_ask_nxt;
  logic [39:0]        held_time_r, held_time_nxt;
  logic               quote_seen_r, quote_seen_nxt;
  logic signed [31:0] last_price_r, last_price_nxt;
  logic               last_seen_r,  last_seen_nxt;
  side_t              last_dir_r,   last_dir_nxt;

  logic               trade_ok;
  logic               age_ok;
  logic               fresh;
  logic [39:0]        age;
  logic signed [33:0] price_x;
  logic signed [33:0] tol_x;
  logic signed [33:0] ask_lo;
  logic signed [33:0] bid_hi;
  logic signed [33:0] last_hi;
  logic signed [33:0] last_lo;
  side_t              side;
  method_t            method;

  // trade validity and quote freshness
  always_comb begin
    trade_ok = item.trade_finite
               && !item.trade_price[31] && (item.trade_price != '0)
               && !item.trade_size[31]  && (item.trade_size  != '0);
    age      = item.time_seconds - held_time_r;
    age_ok   = (item.time_seconds <= held_time_r) || (age <= {8'd0, cfg.max_quote_age});
    fresh    = quote_seen_r && age_ok
               && !held_bid_r[31] && (held_bid_r != '0)
               && (held_ask_r >= held_bid_r);
  end

  // tolerance bounds, exact at 34 bits
  always_comb begin
    price_x = 34'(item.trade_price);
    tol_x   = $signed({3'd0, cfg.price_tolerance});
    ask_lo  = 34'(held_ask_r)   - tol_x;
    bid_hi  = 34'(held_bid_r)   + tol_x;
    last_hi = 34'(last_price_r) + tol_x;
    last_lo = 34'(last_price_r) - tol_x;
  end

  // side decision, quote test first
  always_comb begin
    side   = SIDE_UNKNOWN;
    method = METHOD_UNKNOWN;
    priority if (trade_ok && fresh && (price_x >= ask_lo)) begin
      side   = SIDE_BUY;
      method = METHOD_QUOTE;
    end else if (trade_ok && fresh && (price_x <= bid_hi)) begin
      side   = SIDE_SELL;
      method = METHOD_QUOTE;
    end else if (trade_ok && last_seen_r) begin
      priority if (price_x > last_hi) begin
        side = SIDE_BUY;
      end else if (price_x < last_lo) begin
        side = SIDE_SELL;
      end else begin
        side = last_dir_r;
      end
      method = (side != SIDE_UNKNOWN) ? METHOD_TICK : METHOD_UNKNOWN;
    end else begin
      // invalid trade, or no earlier valid trade to tick against
      side   = SIDE_UNKNOWN;
      method = METHOD_UNKNOWN;
    end
  end

  // result word
  always_comb begin
    res.side      = side;
    res.method    = method;
    res.out_time  = item.time_seconds;
    res.out_price = item.trade_price;
    res.out_size  = item.trade_size;
  end

  // state update when the word leaves the input stage
  always_comb begin
    held_bid_nxt   = held_bid_r;
    held_ask_nxt   = held_ask_r;
    held_time_nxt  = held_time_r;
    quote_seen_nxt = quote_seen_r;
    last_price_nxt = last_price_r;
    last_seen_nxt  = last_seen_r;
    last_dir_nxt   = last_dir_r;
    if (commit) begin
      unique case (item.kind)
        KIND_QUOTE: begin
          held_bid_nxt   = item.quote_bid;
          held_ask_nxt   = item.quote_ask;
          held_time_nxt  = item.time_seconds;
          quote_seen_nxt = 1'b1;
        end
        KIND_TRADE: begin
          if (trade_ok) begin
            last_price_nxt = item.trade_price;
            last_seen_nxt  = 1'b1;
          end
          if (side != SIDE_UNKNOWN) begin
            last_dir_nxt = side;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bid_r   <= '0;
      held_ask_r   <= '0;
      held_time_r  <= '0;
      quote_seen_r <= 1'b0;
      last_price_r <= '0;
      last_seen_r  <= 1'b0;
      last_dir_r   <= SIDE_UNKNOWN;
    end else begin
      held_bid_r   <= held_bid_nxt;
      held_ask_r   <= held_ask_nxt;
      held_time_r  <= held_time_nxt;
      quote_seen_r <= quote_seen_nxt;
      last_price_r <= last_price_nxt;
      last_seen_r  <= last_seen_nxt;
      last_dir_r   <= last_dir_nxt;
    end
  end

endmodule

@@ src/trade_side_classifier.sv @@
// a trade word accepted into the input register is classified from it and, once the
// result register is free, registered there; a stall can hold it in the input stage
// throughput: one word per cycle, quotes and trades alike, unless a trade meets a stall
// quotes update the held quote and produce no result word
// out_ready low holds the result register and stalls a trade in the input stage behind it
// synchronous active-low reset clears both stage valids, the config and the classifier state
module trade_side_classifier
  import tsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_word_t  in_r;
  logic      in_valid_r, in_valid_nxt;
  out_word_t out_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t res;
  logic      s1_go;

  tsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tsc_classify u_cls (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (in_r),
    .commit (s1_go),
    .res    (res)
  );

  // input stage moves on when a quote, or when the result register frees up
  always_comb begin
    s1_go    = in_valid_r && ((in_r.kind == KIND_QUOTE) || !out_valid_r || out_ready);
    in_ready = !in_valid_r || s1_go;
  end

  // stage valids
  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
    end
    if (s1_go && (in_r.kind == KIND_TRADE)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_word;
    end
    if (s1_go && (in_r.kind == KIND_TRADE)) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

@@ src/tsc_checker.sv @@
// port-level checks for the trade side classifier and their bind
module tsc_checker
  import tsc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a trade with nonpositive price or size stays unclassified
  a_invalid_trade: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_word.out_price <= 0) || (out_word.out_size <= 0))
      |-> (out_word.side == SIDE_UNKNOWN) && (out_word.method == METHOD_UNKNOWN))
    else $error("invalid trade was classified");

  // a named method always comes with a side, and no method with no side
  a_method_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_word.method == METHOD_UNKNOWN) == (out_word.side == SIDE_UNKNOWN)))
    else $error("method and side disagree");

endmodule

bind trade_side_classifier tsc_checker u_tsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

@@ tb/tsc_check_pkg.sv @@
// side classification predictor and result checker for the trade side classifier testbench
package tsc_check_pkg;
  import tsc_pkg::*;

  class side_scoreboard;
    // configuration copy
    logic [31:0]        max_age;
    logic [30:0]        tolerance;
    // held quote and tick rule state
    logic signed [31:0] held_bid;
    logic signed [31:0] held_ask;
    logic [39:0]        held_time;
    bit                 quote_seen;
    logic signed [31:0] prev_price;
    bit                 prev_price_seen;
    side_t              prev_side;
    // classified trades waiting for their result word
    out_word_t          classified_trades[$];
    int unsigned        mismatches;

    function new();
      max_age         = '0;
      tolerance       = '0;
      held_bid        = '0;
      held_ask        = '0;
      held_time       = '0;
      quote_seen      = 1'b0;
      prev_price      = '0;
      prev_price_seen = 1'b0;
      prev_side       = SIDE_UNKNOWN;
      mismatches      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_IDX_MAX_QUOTE_AGE) begin
        max_age = data;
      end else if (idx == CFG_IDX_PRICE_TOLERANCE) begin
        tolerance = data[30:0];
      end
    endfunction

    function int pending();
      return classified_trades.size();
    endfunction

    // accepted input word: update the held quote or classify the trade
    function void note_word(in_word_t w);
      logic [39:0] age;
      longint      px;
      longint      tol;
      longint      bid_v;
      longint      ask_v;
      longint      prev_v;
      bit          ok;
      bit          fresh;
      side_t       s;
      method_t     m;
      out_word_t   r;
      if (w.kind == KIND_QUOTE) begin
        held_bid   = w.quote_bid;
        held_ask   = w.quote_ask;
        held_time  = w.time_seconds;
        quote_seen = 1'b1;
        return;
      end
      px     = w.trade_price;
      tol    = {33'd0, tolerance};
      bid_v  = held_bid;
      ask_v  = held_ask;
      prev_v = prev_price;
      ok     = w.trade_finite && (w.trade_price > 0) && (w.trade_size > 0);
      age    = w.time_seconds - held_time;
      // quote ahead of the trade counts as age zero
      fresh  = quote_seen && ((w.time_seconds <= held_time) || (age <= {8'd0, max_age}))
               && (held_bid > 0) && (held_ask >= held_bid);
      s = SIDE_UNKNOWN;
      m = METHOD_UNKNOWN;
      if (ok && fresh && px >= ask_v - tol) begin
        s = SIDE_BUY;
        m = METHOD_QUOTE;
      end else if (ok && fresh && px <= bid_v + tol) begin
        s = SIDE_SELL;
        m = METHOD_QUOTE;
      end else if (ok && prev_price_seen) begin
        // tick rule, equal prints carry the last direction
        if (px > prev_v + tol) begin
          s = SIDE_BUY;
        end else if (px < prev_v - tol) begin
          s = SIDE_SELL;
        end else begin
          s = prev_side;
        end
        if (s != SIDE_UNKNOWN) begin
          m = METHOD_TICK;
        end
      end
      if (ok) begin
        prev_price      = w.trade_price;
        prev_price_seen = 1'b1;
      end
      if (s != SIDE_UNKNOWN) begin
        prev_side = s;
      end
      r.side      = s;
      r.method    = m;
      r.out_time  = w.time_seconds;
      r.out_price = w.trade_price;
      r.out_size  = w.trade_size;
      classified_trades = {classified_trades, r};
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    // accepted result word against the oldest classified trade
    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (classified_trades.size() == 0) begin
        $display("%0t unexpected result word: side %0d method %0d time %0h",
                 $time, got.side, got.method, got.out_time);
        mismatches++;
        return;
      end
      exp_w = classified_trades.pop_front();
      compare_field("side", exp_w.side, got.side);
      compare_field("method", exp_w.method, got.method);
      compare_field("out_time", exp_w.out_time, got.out_time);
      compare_field("out_price", exp_w.out_price, got.out_price);
      compare_field("out_size", exp_w.out_size, got.out_size);
    endfunction
  endclass

endpackage

@@ tb/tb_trade_side_classifier.sv @@
// testbench top for the trade side classifier: directed and random quote/trade streams
module tb_trade_side_classifier;
  import tsc_pkg::*;
  import tsc_check_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  side_scoreboard sb;
  bit             quiet;

  // random stream state
  logic [39:0] clock_sec;
  int          mid_px;
  int          cur_bid;
  int          cur_ask;

  // register settings per random phase
  logic [31:0] age_set [6] = '{32'd0, 32'd5, 32'hFFFF_FFFF, 32'd1, 32'd3, 32'd2};
  logic [31:0] tol_set [6] = '{32'd0, 32'd10, 32'h7FFF_FFFF, 32'd0, 32'd100, 32'hFFFF_FFFF};

  trade_side_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted words, stall now and then
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word(out_word);
    end
    out_ready <= quiet || ($urandom_range(99) >= 8);
  end

  function automatic in_word_t mk_quote(logic [39:0] t, int bid, int ask);
    in_word_t w;
    w.kind         = KIND_QUOTE;
    w.time_seconds = t;
    w.trade_price  = $urandom;
    w.trade_size   = $urandom;
    w.trade_finite = 1'($urandom_range(1));
    w.quote_bid    = bid;
    w.quote_ask    = ask;
    return w;
  endfunction

  function automatic in_word_t mk_trade(logic [39:0] t, int px, int sz, bit fin);
    in_word_t w;
    w.kind         = KIND_TRADE;
    w.time_seconds = t;
    w.trade_price  = px;
    w.trade_size   = sz;
    w.trade_finite = fin;
    w.quote_bid    = $urandom;
    w.quote_ask    = $urandom;
    return w;
  endfunction

  // mostly a time-ordered market stream, with noise and broken words mixed in
  function automatic in_word_t rand_word();
    in_word_t    w;
    logic [63:0] rnd;
    int          d;
    int          px;
    int          sz;
    bit          fin;
    d = int'($urandom_range(40)) - 20;
    if ($urandom_range(99) < 8) begin
      rnd            = {$urandom, $urandom};
      w.kind         = kind_t'($urandom_range(1));
      w.time_seconds = rnd[39:0];
      w.trade_price  = $urandom;
      w.trade_size   = $urandom;
      w.trade_finite = 1'($urandom_range(1));
      w.quote_bid    = $urandom;
      w.quote_ask    = $urandom;
      return w;
    end
    if ($urandom_range(99) < 5) begin
      clock_sec = clock_sec - $urandom_range(1, 6);
    end else if ($urandom_range(2) == 0) begin
      clock_sec = clock_sec + $urandom_range(1, 3);
    end
    if ($urandom_range(3) == 0) begin
      mid_px = mid_px + d;
      if (mid_px < 200) begin
        mid_px = 200;
      end
      cur_bid = mid_px - int'($urandom_range(50));
      cur_ask = mid_px + int'($urandom_range(50));
      // insane quotes: non-positive bid or crossed book
      case ($urandom_range(19))
        0: cur_bid = 0;
        1: cur_bid = -int'($urandom_range(1, 1000));
        2: cur_ask = cur_bid - int'($urandom_range(1, 30));
        default: ;
      endcase
      return mk_quote(clock_sec, cur_bid, cur_ask);
    end
    case ($urandom_range(3))
      0: px = cur_ask + d;
      1: px = cur_bid + d;
      2: px = mid_px + d;
      default: px = mid_px + int'($urandom_range(200)) - 100;
    endcase
    sz  = $urandom_range(1, 100000);
    fin = 1'b1;
    if ($urandom_range(99) < 6) begin
      case ($urandom_range(4))
        0: fin = 1'b0;
        1: px = 0;
        2: px = -int'($urandom_range(1, 5000));
        3: sz = 0;
        default: sz = -int'($urandom_range(1, 5000));
      endcase
    end
    return mk_trade(clock_sec, px, sz, fin);
  endfunction

  task automatic send_word(input in_word_t w);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
  endtask

  // hold the sender until every classified trade has come back, then let quotes settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // run limit
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [63:0] rnd;
    int          ph;
    int          k;
    sb        = new();
    quiet     = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    out_ready <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_IDX_MAX_QUOTE_AGE;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: no quote yet, tick rule with zero tolerance
    send_word(mk_trade(40'd1, 1000, 10, 1'b1));
    send_word(mk_trade(40'd1, 1001, 10, 1'b1));
    send_word(mk_trade(40'd2, 1001, 10, 1'b1));
    send_word(mk_trade(40'd2, 999, 10, 1'b1));
    drain();
    write_reg(CFG_IDX_MAX_QUOTE_AGE, 32'd2);
    // upper data bit lies beyond the tolerance register
    write_reg(CFG_IDX_PRICE_TOLERANCE, 32'h8000_0005);

    // quote test at both edges of the spread, then the tick rule
    send_word(mk_quote(40'd10, 900, 1100));
    send_word(mk_trade(40'd10, 1096, 10, 1'b1));
    send_word(mk_trade(40'd11, 904, 10, 1'b1));
    send_word(mk_trade(40'd12, 1000, 10, 1'b1));
    // invalid trades pass through unclassified
    send_word(mk_trade(40'd12, 1000, 10, 1'b0));
    send_word(mk_trade(40'd12, 0, 5, 1'b1));
    send_word(mk_trade(40'd12, -7, 5, 1'b1));
    send_word(mk_trade(40'd12, 50, 0, 1'b1));
    send_word(mk_trade(40'd12, 50, -1, 1'b1));
    // stale quote, equal print carries the direction
    send_word(mk_trade(40'd13, 1003, 1, 1'b1));
    // quote later than the trade
    send_word(mk_quote(40'd20, 900, 1100));
    send_word(mk_trade(40'd15, 1100, 7, 1'b1));
    // zero bid, crossed book, extreme quote
    send_word(mk_quote(40'd21, 0, 100));
    send_word(mk_trade(40'd21, 200, 1, 1'b1));
    send_word(mk_quote(40'd22, 500, 400));
    send_word(mk_trade(40'd22, 401, 1, 1'b1));
    send_word(mk_quote(40'd23, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_word(mk_trade(40'd23, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1));
    send_word(mk_quote(40'hFF_FFFF_FFFF, 1, 32'sh7FFF_FFFF));
    send_word(mk_trade(40'hFF_FFFF_FFFF, 1, 1, 1'b1));
    send_word(mk_trade(40'd0, 32'sh7FFF_FFFF, 3, 1'b1));

    // random phases, each with its own register setting
    for (ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_IDX_MAX_QUOTE_AGE, age_set[ph]);
      write_reg(CFG_IDX_PRICE_TOLERANCE, tol_set[ph]);
      quiet = (ph == 3);
      rnd   = {$urandom, $urandom};
      if (ph == 2) begin
        clock_sec = 40'hFF_FFFF_FFC0;
      end else begin
        clock_sec = rnd[39:0];
      end
      mid_px  = $urandom_range(1000, 2_000_000);
      cur_bid = mid_px - 10;
      cur_ask = mid_px + 10;
      for (k = 0; k < 115; k++) begin
        send_word(rand_word());
      end
    end
    quiet = 1'b0;

    drain();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/tsc_pkg.sv
src/tsc_cfg_regs.sv
src/tsc_classify.sv
src/trade_side_classifier.sv
src/tsc_checker.sv
tb/tsc_check_pkg.sv
tb/tb_trade_side_classifier.sv
